/* rtl/core/mbps_pkg.sv */
`timescale 1ns / 1ps

package mbps_pkg;

	// Register file geometry: 64-bit registers at byte address 8*i
	localparam int APB_ADDR_W  = 6;
	localparam int APB_DATA_W  = 64;
	localparam int REG_IDX_LSB = 3;
	localparam int REG_IDX_W   = 3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAT_MID = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAT_HI  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CARE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET  = 3'd5;

	// Pattern bytes backed by registers; positions above are wildcards
	localparam int PAT_REG_BYTES = 24;
	localparam int PAT_WORDS     = 3;
	localparam int BYTES_PER_WORD = 8;
	localparam int LENGTH_W      = 5;
	localparam int OFFSET_W      = 16;
	localparam int ADDR_W        = 64;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic [ADDR_W-1:0] byte_address;
		logic              region_first;
		logic              region_last;
	} scan_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} result_item_t;

endpackage

/* rtl/core/masked_byte_pattern_scanner.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// scan      in   scan_valid / scan_ready       scan_item   (scan_item_t)
// result    out  result_valid / result_ready   result_item (result_item_t)
// config    in   APB psel/penable/pwrite       paddr, pwdata / prdata
//
// One byte request per cycle, sustained unless a result stall holds stage 1.
// A request lands in the window register and stage 1 at its accepting edge;
// the parallel window compare and the address add run in stage 1, and the
// result register loads from stage 1 once it is free to take a result.
// Reset clears the window, the region flags and both pipeline valids; no
// clearing pass is needed. A stall on the result side holds stage 1 when it has a
// result to give; scan_ready stays low until the result register frees up.

module masked_byte_pattern_scanner import mbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  scan_valid,
	output logic                  scan_ready,
	input  scan_item_t            scan_item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_item_t          result_item
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

	// Aligned config from the register block
	logic [MAX_PATTERN_BYTES-1:0][7:0] pat_al_q;
	logic [MAX_PATTERN_BYTES-1:0]      care_al_q;
	logic [LEN_W-1:0]                  len_q;
	logic [ADDR_W-1:0]                 adj_q;

	// Region state, always describing the request held in stage 1
	logic [MAX_PATTERN_BYTES-1:0][7:0] window_q;
	logic [LEN_W-1:0]                  bytes_seen_q;
	logic                              match_reported_q;
	logic                              restart_q;

	// Stage 1
	logic                              valid_s1;
	logic [ADDR_W-1:0]                 addr_s1;
	logic                              first_s1;
	logic                              last_s1;

	logic                              scan_acc;
	logic                              first_eff;
	logic                              hit;
	logic                              reported_eff;
	logic                              has_result;
	logic                              out_free;
	logic                              adv_s1;
	result_item_t                      result_d;

	mbps_cfg #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.LEN_W(LEN_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pat_al_q (pat_al_q),
		.care_al_q(care_al_q),
		.len_q    (len_q),
		.adj_q    (adj_q)
	);

	mbps_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.LEN_W(LEN_W)
	) u_match (
		.window    (window_q),
		.pat_al    (pat_al_q),
		.care_al   (care_al_q),
		.bytes_seen(bytes_seen_q),
		.len       (len_q),
		.hit       (hit)
	);

	// Handshake chain: stage 1 moves on when it has nothing to give or
	// the result register can take it.
	assign out_free   = !result_valid || result_ready;
	assign adv_s1     = valid_s1 && (!has_result || out_free);
	assign scan_ready = !valid_s1 || adv_s1;
	assign scan_acc   = scan_valid && scan_ready;

	// A byte after a region's last byte starts a new region on its own
	assign first_eff  = scan_item.region_first || restart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			bytes_seen_q <= '0;
			restart_q    <= 1'b0;
		end else if (scan_acc) begin
			restart_q <= scan_item.region_last;
			// a new region starts from an empty window
			for (int j = MAX_PATTERN_BYTES - 1; j > 0; j--) begin
				window_q[j] <= first_eff ? 8'h00 : window_q[j-1];
			end
			window_q[0] <= scan_item.data_byte;
			if (first_eff) begin
				bytes_seen_q <= LEN_W'(1);
			end else if (bytes_seen_q < LEN_W'(MAX_PATTERN_BYTES)) begin
				bytes_seen_q <= bytes_seen_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_ready) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_acc) begin
			addr_s1  <= scan_item.byte_address;
			first_s1 <= first_eff;
			last_s1  <= scan_item.region_last;
		end
	end

	// Only the first match of a region reports; a new region forgets it
	assign reported_eff = match_reported_q && !first_s1;
	assign has_result   = (hit && !reported_eff) || (last_s1 && !reported_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_reported_q <= 1'b0;
		end else if (adv_s1) begin
			match_reported_q <= !last_s1 && (reported_eff || hit);
		end
	end

	always_comb begin
		result_d.found         = hit && !reported_eff;
		result_d.match_address = result_d.found ? (addr_s1 + adj_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= adv_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && has_result) begin
			result_item <= result_d;
		end
	end

	// A held stage 1 must block new bytes, or the window runs ahead of it
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !scan_ready)
		else $error("scan accepted while stage 1 is held");

	// The byte after a region's last byte restarts the window
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		scan_acc && scan_item.region_last |=> restart_q)
		else $error("region end did not arm a restart");

	// Region end forgets any reported match
	a_region_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> !match_reported_q)
		else $error("match flag survived the region end");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= LEN_W'(MAX_PATTERN_BYTES))
		else $error("byte count past window depth");

endmodule

/* rtl/core/mbps_cfg.sv */
`timescale 1ns / 1ps

module mbps_cfg import mbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = 24,
	parameter int LEN_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [APB_ADDR_W-1:0]               paddr,
	input  logic [APB_DATA_W-1:0]               pwdata,
	output logic [APB_DATA_W-1:0]               prdata,
	output logic                                pready,
	output logic [MAX_PATTERN_BYTES-1:0][7:0]   pat_al_q,
	output logic [MAX_PATTERN_BYTES-1:0]        care_al_q,
	output logic [LEN_W-1:0]                    len_q,
	output logic [ADDR_W-1:0]                   adj_q
);

	localparam int CMP_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
	localparam int PAT_N = (MAX_PATTERN_BYTES < PAT_REG_BYTES) ?
		MAX_PATTERN_BYTES : PAT_REG_BYTES;

	logic [PAT_WORDS-1:0][APB_DATA_W-1:0] pat_words_q;
	logic [PAT_REG_BYTES-1:0]             care_mask_q;
	logic [LENGTH_W-1:0]                  pattern_length_q;
	logic [OFFSET_W-1:0]                  result_offset_q;

	logic                                 wr_en;
	logic [REG_IDX_W-1:0]                 reg_idx;
	logic [CMP_W-1:0]                     len_ext;
	logic [CMP_W-1:0]                     len_sat;
	logic [LEN_W-1:0]                     len_eff;
	logic [MAX_PATTERN_BYTES-1:0][7:0]    pat_al_d;
	logic [MAX_PATTERN_BYTES-1:0]         care_al_d;
	logic [ADDR_W-1:0]                    adj_d;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[REG_IDX_LSB +: REG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_words_q      <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= LENGTH_W'(1);
			result_offset_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PAT_LO:  pat_words_q[0]   <= pwdata;
				REG_PAT_MID: pat_words_q[1]   <= pwdata;
				REG_PAT_HI:  pat_words_q[2]   <= pwdata;
				REG_CARE:    care_mask_q      <= pwdata[PAT_REG_BYTES-1:0];
				REG_LENGTH:  pattern_length_q <= pwdata[LENGTH_W-1:0];
				REG_OFFSET:  result_offset_q  <= pwdata[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAT_LO:  prdata = pat_words_q[0];
			REG_PAT_MID: prdata = pat_words_q[1];
			REG_PAT_HI:  prdata = pat_words_q[2];
			REG_CARE:    prdata = APB_DATA_W'(care_mask_q);
			REG_LENGTH:  prdata = APB_DATA_W'(pattern_length_q);
			REG_OFFSET:  prdata = APB_DATA_W'(result_offset_q);
			default:     prdata = '0;
		endcase
	end

	// Saturate the length at the window depth
	assign len_ext = CMP_W'(pattern_length_q);
	assign len_sat = (len_ext > CMP_W'(MAX_PATTERN_BYTES)) ?
		CMP_W'(MAX_PATTERN_BYTES) : len_ext;
	assign len_eff = LEN_W'(len_sat);

	// Align the pattern to the window: window slot j (0 = newest) meets
	// pattern byte len-1-j. Slots at or past the length stay wildcards.
	always_comb begin
		pat_al_d  = '0;
		care_al_d = '0;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			for (int i = 0; i < PAT_N; i++) begin
				if (int'(len_eff) == i + j + 1) begin
					pat_al_d[j]  = pat_words_q[i / BYTES_PER_WORD]
						[(i % BYTES_PER_WORD) * 8 +: 8];
					care_al_d[j] = care_mask_q[i];
				end
			end
		end
	end

	// start address = addr - (len - 1); folded with the offset
	assign adj_d = ADDR_W'(result_offset_q) + ADDR_W'(1) - ADDR_W'(len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_al_q  <= '0;
			care_al_q <= '0;
			len_q     <= LEN_W'(1);
			adj_q     <= '0;
		end else begin
			pat_al_q  <= pat_al_d;
			care_al_q <= care_al_d;
			len_q     <= len_eff;
			adj_q     <= adj_d;
		end
	end

endmodule

/* rtl/core/mbps_match.sv */
`timescale 1ns / 1ps

module mbps_match #(
	parameter int MAX_PATTERN_BYTES = 24,
	parameter int LEN_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  logic [MAX_PATTERN_BYTES-1:0][7:0] window,
	input  logic [MAX_PATTERN_BYTES-1:0][7:0] pat_al,
	input  logic [MAX_PATTERN_BYTES-1:0]      care_al,
	input  logic [LEN_W-1:0]                  bytes_seen,
	input  logic [LEN_W-1:0]                  len,
	output logic                              hit
);

	logic [MAX_PATTERN_BYTES-1:0] slot_ok;

	always_comb begin
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			slot_ok[j] = !care_al[j] || (window[j] == pat_al[j]);
		end
	end

	assign hit = (len != '0) && (bytes_seen >= len) && (&slot_ok);

endmodule
